[hw/rtl/p1305_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package p1305_pkg;

    localparam int LIMB_W   = 26;
    localparam int NLIMB    = 5;
    localparam int ACC_W    = LIMB_W * NLIMB;   // 130
    localparam int BLOCK_W  = 128;
    localparam int COUNT_W  = 5;
    localparam int KEY_W    = 64;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_R_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_S_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_S_HIGH = 2'd3;

    localparam logic [LIMB_W-1:0] LIMB_MASK = 26'h3ffffff;
    localparam logic [LIMB_W-1:0] CLAMP_1   = 26'h3ffff03;
    localparam logic [LIMB_W-1:0] CLAMP_2   = 26'h3ffc0ff;
    localparam logic [LIMB_W-1:0] CLAMP_3   = 26'h3f03fff;
    localparam logic [LIMB_W-1:0] CLAMP_4   = 26'h00fffff;

    typedef logic [NLIMB-1:0][LIMB_W-1:0] limbs_t;

    // one classified word on its way from front to back
    typedef struct packed {
        logic [ACC_W-1:0] msg;      // padded block, 130 bits
        logic             absorb;   // block carries at least one byte
        logic             last;     // emit the tag after this word
    } entry_t;

    // split r into limbs and clamp
    function automatic limbs_t clamp_r(input logic [BLOCK_W-1:0] r);
        limbs_t l;
        l[0] = r[25:0]   & LIMB_MASK;
        l[1] = r[51:26]  & CLAMP_1;
        l[2] = r[77:52]  & CLAMP_2;
        l[3] = r[103:78] & CLAMP_3;
        l[4] = {2'b00, r[127:104]} & CLAMP_4;
        return l;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/p1305_front.sv]
`timescale 1ns / 1ps
`default_nettype none

// Classify an incoming word and pad its block.
module p1305_front (
    input  wire logic [p1305_pkg::BLOCK_W-1:0] block,
    input  wire logic [p1305_pkg::COUNT_W-1:0] byte_count,
    input  wire logic                          last,
    output p1305_pkg::entry_t                  entry
);

    logic [p1305_pkg::BLOCK_W-1:0] masked;
    logic                          full;

    always_comb
    begin
        full = (byte_count >= p1305_pkg::COUNT_W'(16));
        masked = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (full || (p1305_pkg::COUNT_W'(i) < byte_count))
            begin
                masked[8*i +: 8] = block[8*i +: 8];
            end
            else if (p1305_pkg::COUNT_W'(i) == byte_count)
            begin
                masked[8*i] = 1'b1;
            end
        end
        entry.msg    = {1'b0, full, masked};
        entry.absorb = (byte_count != '0);
        entry.last   = last;
    end

endmodule

`default_nettype wire

[hw/rtl/p1305_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

// Short queue between front and back.
module p1305_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire p1305_pkg::entry_t wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output p1305_pkg::entry_t      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    p1305_pkg::entry_t mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/p1305_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

// Absorb a block: h = acc + m, then acc = h * r mod 2^130-5, one limb per cycle.
module p1305_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire p1305_pkg::limbs_t           r,
    input  wire logic                        q_valid,
    output logic                             q_ready,
    input  wire p1305_pkg::entry_t           q_data,
    output logic                             tag_valid,
    input  wire logic                        tag_ready,
    output logic [p1305_pkg::ACC_W-1:0]      tag_h
);

    localparam int PROD_W = 60;
    localparam int CARRY_W = PROD_W - p1305_pkg::LIMB_W;
    localparam logic [2:0] FOLD_STEP = 3'd5;

    logic [4:0][26:0]   h_reg;
    p1305_pkg::limbs_t  acc_reg, acc_next, limb_reg, limb_next, fold;
    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic [2:0]         step_reg, step_next;
    logic               busy_reg, busy_next, last_reg, last_next;
    logic [4:0][26:0]   h_next;

    logic [4:0][28:0]   r5;
    logic [4:0][28:0]   rmul;
    logic [PROD_W-1:0]  dsum;
    logic [2:0]         ri;
    logic [38:0]        t0;
    logic [26:0]        v1, v2, v3, v4, l0n, l1n;
    logic               pass_now, fold_done;

    // limb products for the current output limb
    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            r5[k] = {3'b000, r[k]} + {1'b0, r[k], 2'b00};
        end
        dsum = PROD_W'(carry_reg);
        for (int k = 0; k < 5; k++)
        begin
            ri = (3'(k) <= step_reg) ? step_reg - 3'(k) : step_reg + 3'(5 - k);
            rmul[k] = (3'(k) <= step_reg) ? {3'b000, r[ri]} : r5[ri];
            dsum = dsum + PROD_W'({29'd0, h_reg[k]} * {27'd0, rmul[k]});
        end
    end

    // fold the top carry back into limb 0 (times 5) and settle the carries
    always_comb
    begin
        t0  = 39'(limb_reg[0]) + 39'(carry_reg) * 39'd5;
        v1  = 27'(limb_reg[1]) + 27'(t0[38:26]);
        v2  = 27'(limb_reg[2]) + 27'(v1[26]);
        v3  = 27'(limb_reg[3]) + 27'(v2[26]);
        v4  = 27'(limb_reg[4]) + 27'(v3[26]);
        l0n = 27'(t0[25:0]) + (v4[26] ? 27'd5 : 27'd0);
        l1n = 27'(v1[25:0]) + 27'(l0n[26]);
        fold[0] = l0n[25:0];
        fold[1] = l1n[25:0];
        fold[2] = v2[25:0];
        fold[3] = v3[25:0];
        fold[4] = v4[25:0];
    end

    // a zero-byte final word hands the accumulator straight over
    assign pass_now  = !busy_reg && q_valid && !q_data.absorb && q_data.last;
    assign fold_done = busy_reg && (step_reg == FOLD_STEP) && (!last_reg || tag_ready);
    assign q_ready   = !busy_reg && (!pass_now || tag_ready);
    assign tag_valid = pass_now || (busy_reg && (step_reg == FOLD_STEP) && last_reg);
    assign tag_h     = busy_reg ? fold : acc_reg;

    always_comb
    begin
        acc_next   = acc_reg;
        limb_next  = limb_reg;
        carry_next = carry_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        last_next  = last_reg;
        h_next     = h_reg;
        if (!busy_reg)
        begin
            if (q_valid && q_ready)
            begin
                if (q_data.absorb)
                begin
                    for (int k = 0; k < 5; k++)
                    begin
                        h_next[k] = 27'(acc_reg[k]) + 27'(q_data.msg[26*k +: 26]);
                    end
                    busy_next  = 1'b1;
                    step_next  = '0;
                    carry_next = '0;
                    last_next  = q_data.last;
                end
                else if (q_data.last)
                begin
                    acc_next = '0;
                end
            end
        end
        else if (step_reg != FOLD_STEP)
        begin
            limb_next[step_reg] = dsum[25:0];
            carry_next = dsum[PROD_W-1:26];
            step_next  = step_reg + 1'b1;
        end
        else if (fold_done)
        begin
            acc_next  = last_reg ? '0 : fold;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg     <= h_next;
        limb_reg  <= limb_next;
        carry_reg <= carry_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/p1305_tag.sv]
`timescale 1ns / 1ps
`default_nettype none

// Final reduction and pad addition, three registered stages.
module p1305_tag (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [p1305_pkg::BLOCK_W-1:0] s,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [p1305_pkg::ACC_W-1:0] in_h,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [p1305_pkg::BLOCK_W-1:0]    out_tag
);

    logic [p1305_pkg::ACC_W-1:0]   h_reg;
    logic [p1305_pkg::BLOCK_W-1:0] red_reg, tag_reg;
    logic                          v1_reg, v2_reg, v3_reg;
    logic                          rdy2, rdy3;
    logic [p1305_pkg::ACC_W:0]     g;

    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign in_ready  = !v1_reg || rdy2;
    assign out_valid = v3_reg;
    assign out_tag   = tag_reg;

    // subtract p once when h + 5 reaches 2^130
    assign g = {1'b0, h_reg} + (p1305_pkg::ACC_W + 1)'(5);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            h_reg <= in_h;
        end
        if (v1_reg && rdy2)
        begin
            red_reg <= g[p1305_pkg::ACC_W] ? g[p1305_pkg::BLOCK_W-1:0]
                                           : h_reg[p1305_pkg::BLOCK_W-1:0];
        end
        if (v2_reg && rdy3)
        begin
            tag_reg <= red_reg + s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/poly1305_mac_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

// Poly1305 authenticator. Load the 32-byte key through the configuration channel
// (index 0 r_low, 1 r_high, 2 s_low, 3 s_high) while the engine is idle, then stream
// message blocks of 1 to 16 bytes; tlast marks the final block of a message and one
// 16-byte tag word follows it, after which the accumulator clears and the key stays.
// A block with a byte count of zero is not absorbed; with tlast it still yields the
// tag of what has been absorbed so far. The front pads each block and queues it, so
// input words are taken while the multiplier works. Each absorbed block holds the
// shared limb multiplier through its steps in order: a take from the queue and add into
// the accumulator, then one step per 26-bit result limb, each summing five 27x29-bit
// limb products, then a fold of the top carry back in modulo 2^130-5. Zero-byte words
// pass the back end without a multiply. After the last block leaves the multiplier,
// the tag passes the input, reduce and add-s registers, the last of which drives the output.
module poly1305_mac_engine #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    // message blocks
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,  // block_low[63:0], block_high[127:64],
                                             // byte_count[132:128], zero fill
    input  wire logic         s_axis_tlast,  // final_block
    // tags
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata   // tag_low[63:0], tag_high[127:64]
);

    logic [63:0] r_low_reg, r_high_reg, s_low_reg, s_high_reg;

    p1305_pkg::entry_t  front_entry, q_entry;
    p1305_pkg::limbs_t  r_limbs;
    logic               q_valid, q_ready;
    logic               tag_valid, tag_ready;
    logic [p1305_pkg::ACC_W-1:0] tag_h;

    // key registers: always ready, hold across messages
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_low_reg  <= '0;
            r_high_reg <= '0;
            s_low_reg  <= '0;
            s_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                p1305_pkg::REG_R_LOW:  r_low_reg  <= cfg_data;
                p1305_pkg::REG_R_HIGH: r_high_reg <= cfg_data;
                p1305_pkg::REG_S_LOW:  s_low_reg  <= cfg_data;
                p1305_pkg::REG_S_HIGH: s_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp r once; the user keeps key changes to idle times, the block does not enforce it
    assign r_limbs = p1305_pkg::clamp_r({r_high_reg, r_low_reg});

    p1305_front u_front (
        .block      (s_axis_tdata[127:0]),
        .byte_count (s_axis_tdata[132:128]),
        .last       (s_axis_tlast),
        .entry      (front_entry)
    );

    p1305_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_axis_tvalid),
        .wr_ready (s_axis_tready),
        .wr_data  (front_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_entry)
    );

    p1305_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .r         (r_limbs),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_entry),
        .tag_valid (tag_valid),
        .tag_ready (tag_ready),
        .tag_h     (tag_h)
    );

    p1305_tag u_tag (
        .clk       (clk),
        .rst_n     (rst_n),
        .s         ({s_high_reg, s_low_reg}),
        .in_valid  (tag_valid),
        .in_ready  (tag_ready),
        .in_h      (tag_h),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tag   (m_axis_tdata)
    );

endmodule

`default_nettype wire
